// ===== rtl/segmed_pkg.sv =====
package segmed_pkg;

    localparam int MAX_SEGMENT = 256;
    localparam int ADDR_BITS   = $clog2(MAX_SEGMENT);
    localparam int CNT_BITS    = $clog2(MAX_SEGMENT + 1);
    localparam int DATA_BITS   = 32;
    localparam int NUM_BITS    = 16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture input word
        logic scan_rd;    // read store entry below next scan address
        logic scan_step;  // shift entry up one slot, move scan address down
        logic place;      // write held sample at scan address, count up
        logic drop;       // set dropped flag
        logic med_rd;     // read first median entry
        logic med_rd2;    // read second median entry
        logic emit;       // build result into output register
        logic emit_last;  // result is the column end result
        logic close_seg;  // clear fill and drop, bump segment number
        logic end_col;    // clear fill, drop, have_prev, segment number
        logic set_prev;   // remember id
    } t_cmd;

    typedef struct packed {
        logic id_change;  // have previous and id differs
        logic col_end;
        logic full;
        logic scan_done;  // scan address at zero or sample not below entry
        logic odd;
    } t_stat;

endpackage

// ===== rtl/segmed_datapath.sv =====
module segmed_datapath
    import segmed_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [DATA_BITS-1:0] i_sample,
    input  logic [31:0]          i_segment_id,
    input  logic                 i_column_end,
    output logic [DATA_BITS-1:0] o_median,
    output logic [NUM_BITS-1:0]  o_segment_number,
    output logic [CNT_BITS-1:0]  o_segment_length,
    output logic                 o_overflow,
    output logic                 o_last
);

    logic [DATA_BITS-1:0] r_mem [MAX_SEGMENT];
    logic [DATA_BITS-1:0] r_rd;
    logic [DATA_BITS-1:0] r_rd_a;
    logic [DATA_BITS-1:0] r_sample;
    logic [31:0]          r_id;
    logic                 r_end;
    logic [31:0]          r_prev_id;
    logic                 r_have_prev;
    logic [CNT_BITS-1:0]  r_fill;
    logic [CNT_BITS-1:0]  r_pos;
    logic                 r_rd_ok;
    logic [NUM_BITS-1:0]  r_segnum;
    logic                 r_drop;
    logic [CNT_BITS-1:0]  n_pos;
    logic [ADDR_BITS-1:0] w_rd_addr;
    logic                 w_below;
    logic [DATA_BITS:0]   w_sum;
    logic [DATA_BITS:0]   w_half;

    // scan reads the entry below the next position; r_rd_ok marks that r_rd holds it
    always_comb begin
        priority if (i_cmd.med_rd) begin
            w_rd_addr = r_fill[CNT_BITS-1:1] - (r_fill[0] ? ADDR_BITS'(0) : ADDR_BITS'(1));
        end else if (i_cmd.med_rd2) begin
            w_rd_addr = r_fill[ADDR_BITS:1];
        end else begin
            w_rd_addr = n_pos[ADDR_BITS-1:0] - ADDR_BITS'(1);
        end
    end

    assign w_below = $signed(r_sample) < $signed(r_rd);
    assign o_stat.id_change = r_have_prev && (r_id != r_prev_id);
    assign o_stat.col_end   = r_end;
    assign o_stat.full      = r_fill == CNT_BITS'(MAX_SEGMENT);
    assign o_stat.scan_done = (r_pos == '0) || (r_rd_ok && !w_below);
    assign o_stat.odd       = r_fill[0];

    assign n_pos = i_cmd.scan_step ? r_pos - CNT_BITS'(1) : r_pos;

    // exact sum of the two middle entries, halved toward zero
    assign w_sum  = {r_rd_a[DATA_BITS-1], r_rd_a} + {r_rd[DATA_BITS-1], r_rd};
    assign w_half = {w_sum[DATA_BITS], w_sum[DATA_BITS:1]}
                  + {{DATA_BITS{1'b0}}, w_sum[DATA_BITS] & w_sum[0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_id     <= i_segment_id;
            r_end    <= i_column_end;
        end
        r_rd <= r_mem[w_rd_addr];
        if (i_cmd.med_rd2) begin
            r_rd_a <= r_rd;
        end
        if (i_cmd.scan_step) begin
            r_mem[r_pos[ADDR_BITS-1:0]] <= r_rd;
        end else if (i_cmd.place) begin
            r_mem[r_pos[ADDR_BITS-1:0]] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_id   <= '0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_rd_ok     <= 1'b0;
            r_segnum    <= '0;
            r_drop      <= 1'b0;
            o_last      <= 1'b0;
        end else begin
            r_rd_ok <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_pos <= r_fill;
            end else if (i_cmd.close_seg || i_cmd.end_col) begin
                r_pos <= '0;
            end else begin
                r_pos <= n_pos;
            end
            if (i_cmd.place) begin
                r_fill <= r_fill + CNT_BITS'(1);
            end
            if (i_cmd.drop) begin
                r_drop <= 1'b1;
            end
            if (i_cmd.set_prev) begin
                r_prev_id   <= r_id;
                r_have_prev <= 1'b1;
            end
            if (i_cmd.emit) begin
                o_median         <= r_fill[0] ? r_rd : w_half[DATA_BITS-1:0];
                o_segment_length <= r_fill;
                o_segment_number <= r_segnum;
                o_overflow       <= r_drop;
                o_last           <= i_cmd.emit_last;
            end
            if (i_cmd.close_seg) begin
                r_fill   <= '0;
                r_drop   <= 1'b0;
                r_segnum <= r_segnum + NUM_BITS'(1);
            end
            if (i_cmd.end_col) begin
                r_fill      <= '0;
                r_drop      <= 1'b0;
                r_segnum    <= '0;
                r_have_prev <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_BITS'(MAX_SEGMENT)) else $error("fill above capacity");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_fill) else $error("scan position beyond fill");
    a_no_place_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place |-> !o_stat.full) else $error("write into full store");
`endif

endmodule

// ===== rtl/segmed_ctrl.sv =====
module segmed_ctrl
    import segmed_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_CMRD  = 10'b0000000100,
        S_CMRD2 = 10'b0000001000,
        S_CWAIT = 10'b0000010000,
        S_SCAN  = 10'b0000100000,
        S_EMRD  = 10'b0001000000,
        S_EMRD2 = 10'b0010000000,
        S_EEMIT = 10'b0100000000,
        S_EWAIT = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid;

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_ovalid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.id_change) begin
                    // hold until the previous result word is taken
                    if (!r_ovalid) begin
                        o_cmd.med_rd = 1'b1;
                        n_state      = S_CMRD;
                    end
                end else if (i_stat.full) begin
                    o_cmd.drop     = 1'b1;
                    o_cmd.set_prev = 1'b1;
                    n_state        = i_stat.col_end ? S_EMRD : S_IDLE;
                    if (i_stat.col_end) o_cmd.med_rd = 1'b1;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_CMRD: begin
                o_cmd.med_rd2 = 1'b1;
                n_state       = S_CMRD2;
            end
            S_CMRD2: begin
                o_cmd.emit      = 1'b1;
                o_cmd.close_seg = 1'b1;
                n_state         = S_CWAIT;
            end
            S_CWAIT: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.place    = 1'b1;
                    o_cmd.set_prev = 1'b1;
                    n_state        = i_stat.col_end ? S_EMRD : S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.scan_rd   = 1'b1;
                end
            end
            S_EMRD: begin
                if (!r_ovalid) begin
                    o_cmd.med_rd = 1'b1;
                    n_state      = S_EMRD2;
                end
            end
            S_EMRD2: begin
                o_cmd.med_rd2 = 1'b1;
                n_state       = S_EEMIT;
            end
            S_EEMIT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
                o_cmd.end_col   = 1'b1;
                n_state         = S_EWAIT;
            end
            S_EWAIT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !r_ovalid) else $error("emit over held word");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
`endif

endmodule

// ===== rtl/segment_median.sv =====
// segment_median: streaming median of each run of equal segment ids in a column.
// Each word is insertion-sorted into a 256-entry store by a scan that reads one
// entry per cycle and shifts up each entry above the word. A closed segment or a
// column end also waits while an earlier result word is still held. Words beyond
// 256 per segment are dropped without a scan and flag overflow.
module segment_median
    import segmed_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_sample,
    input  logic [31:0] i_segment_id,
    input  logic        i_column_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_median,
    output logic [15:0] o_segment_number,
    output logic [8:0]  o_segment_length,
    output logic        o_overflow,
    output logic        o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    segmed_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    segmed_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_sample         (i_sample),
        .i_segment_id     (i_segment_id),
        .i_column_end     (i_column_end),
        .o_median         (o_median),
        .o_segment_number (o_segment_number),
        .o_segment_length (o_segment_length),
        .o_overflow       (o_overflow),
        .o_last           (o_last)
    );

endmodule
